[src/cpsw_pkg.sv]
// ----------------------------------------------------------------------------
// cpsw_pkg
// Types and constants shared by the conveyor pulse sensor watchdog modules.
// ----------------------------------------------------------------------------
package cpsw_pkg;

   localparam int unsigned CFG_WIDTH      = 20;
   localparam int unsigned CSR_IDX_WIDTH  = 2;
   localparam int unsigned STAT_OUT_WIDTH = 20;
   localparam int unsigned STAT_RESET_MIN = 1000;

   localparam logic [CFG_WIDTH-1:0] ON_FILTER_TIME_RESET = CFG_WIDTH'(100);
   localparam logic [CFG_WIDTH-1:0] OFF_TIME_LIMIT_RESET = CFG_WIDTH'(2000);
   localparam logic [CFG_WIDTH-1:0] ON_TIME_LIMIT_RESET  = CFG_WIDTH'(2000);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ON_FILTER_TIME = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OFF_TIME_LIMIT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ON_TIME_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      MODE_INIT      = 3'd0,
      MODE_BELT_OFF  = 3'd1,
      MODE_OFF       = 3'd2,
      MODE_SIM_ON    = 3'd3,
      MODE_ON_FILTER = 3'd4,
      MODE_ON        = 3'd5,
      MODE_SIM_OFF   = 3'd6
   } mode_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] on_filter_time;
      logic [CFG_WIDTH-1:0] off_time_limit;
      logic [CFG_WIDTH-1:0] on_time_limit;
   } cfg_type;

   typedef struct packed {
      logic belt_running;
      logic sensor_level;
   } req_type;

   typedef struct packed {
      logic                      pulse_detected;
      logic                      alarm_off_long;
      logic                      alarm_on_long;
      logic [STAT_OUT_WIDTH-1:0] off_time_min;
      logic [STAT_OUT_WIDTH-1:0] off_time_max;
      logic [STAT_OUT_WIDTH-1:0] on_time_min;
      logic [STAT_OUT_WIDTH-1:0] on_time_max;
   } rsp_type;

endpackage

[src/cpsw_core.sv]
// ----------------------------------------------------------------------------
// cpsw_core
// Mode register, on/off duration counters and pulse statistics; computes the
// transaction result for the current sample and updates state on advance.
// ----------------------------------------------------------------------------
module cpsw_core #(
   parameter int unsigned TICK_STEP   = 10,
   parameter int unsigned COUNT_WIDTH = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cpsw_pkg::cfg_type cfg,
   input  cpsw_pkg::req_type sample,
   output cpsw_pkg::rsp_type result
);

   localparam int unsigned CMP_W = (COUNT_WIDTH > cpsw_pkg::CFG_WIDTH) ?
                                   COUNT_WIDTH : cpsw_pkg::CFG_WIDTH;
   localparam int unsigned SUM_W = COUNT_WIDTH + 11;
   localparam logic [SUM_W-1:0]       STEP      = SUM_W'(TICK_STEP);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CMP_W-1:0]       STAT_MIN0 = CMP_W'(cpsw_pkg::STAT_RESET_MIN);

   cpsw_pkg::mode_type     mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] on_count_ff, on_count_in;
   logic [COUNT_WIDTH-1:0] off_count_ff, off_count_in;
   logic [CMP_W-1:0]       off_min_ff, off_min_in;
   logic [CMP_W-1:0]       off_max_ff, off_max_in;
   logic [CMP_W-1:0]       on_min_ff, on_min_in;
   logic [CMP_W-1:0]       on_max_ff, on_max_in;

   logic [SUM_W-1:0]       on_sum, off_sum;
   logic [COUNT_WIDTH-1:0] on_sat, off_sat;
   logic [CMP_W-1:0]       on_ext, off_ext;
   logic [CMP_W-1:0]       filter_ext, off_lim_ext, on_lim_ext;
   logic                   det, aoff, aon;

   assign on_sum  = SUM_W'(on_count_ff) + STEP;
   assign off_sum = SUM_W'(off_count_ff) + STEP;
   assign on_sat  = (on_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : on_sum[COUNT_WIDTH-1:0];
   assign off_sat = (off_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : off_sum[COUNT_WIDTH-1:0];
   assign on_ext      = CMP_W'(on_sat);
   assign off_ext     = CMP_W'(off_sat);
   assign filter_ext  = CMP_W'(cfg.on_filter_time);
   assign off_lim_ext = CMP_W'(cfg.off_time_limit);
   assign on_lim_ext  = CMP_W'(cfg.on_time_limit);

   always_comb begin
      mode_in      = mode_ff;
      on_count_in  = on_count_ff;
      off_count_in = off_count_ff;
      off_min_in   = off_min_ff;
      off_max_in   = off_max_ff;
      on_min_in    = on_min_ff;
      on_max_in    = on_max_ff;
      det          = 1'b0;
      aoff         = 1'b0;
      aon          = 1'b0;
      unique case (mode_ff)
         cpsw_pkg::MODE_BELT_OFF: begin
            if (sample.belt_running) begin
               on_count_in  = '0;
               off_count_in = '0;
               mode_in      = sample.sensor_level ? cpsw_pkg::MODE_ON : cpsw_pkg::MODE_OFF;
            end
         end
         cpsw_pkg::MODE_OFF: begin
            off_count_in = off_sat;
            if (!sample.belt_running) begin
               mode_in = cpsw_pkg::MODE_BELT_OFF;
            end else if (off_ext > off_lim_ext) begin
               aoff        = 1'b1;
               det         = 1'b1;
               on_count_in = '0;
               mode_in     = cpsw_pkg::MODE_SIM_ON;
            end else if (sample.sensor_level) begin
               if (off_ext > off_max_ff) off_max_in = off_ext;
               if (off_ext < off_min_ff) off_min_in = off_ext;
               det         = 1'b1;
               on_count_in = '0;
               mode_in     = cpsw_pkg::MODE_ON_FILTER;
            end
         end
         cpsw_pkg::MODE_SIM_ON: begin
            on_count_in = on_sat;
            if (!sample.belt_running) begin
               mode_in = cpsw_pkg::MODE_BELT_OFF;
            end else if (sample.sensor_level) begin
               on_count_in = '0;
               mode_in     = cpsw_pkg::MODE_ON_FILTER;
            end else if (on_ext > on_lim_ext) begin
               off_count_in = '0;
               mode_in      = cpsw_pkg::MODE_OFF;
            end
         end
         cpsw_pkg::MODE_ON_FILTER: begin
            on_count_in = on_sat;
            if (!sample.belt_running) begin
               mode_in = cpsw_pkg::MODE_BELT_OFF;
            end else if (on_ext > filter_ext) begin
               mode_in = cpsw_pkg::MODE_ON;
            end
         end
         cpsw_pkg::MODE_ON: begin
            on_count_in = on_sat;
            if (!sample.belt_running) begin
               mode_in = cpsw_pkg::MODE_BELT_OFF;
            end else if (on_ext > on_lim_ext) begin
               off_count_in = '0;
               aon          = 1'b1;
               mode_in      = cpsw_pkg::MODE_SIM_OFF;
            end else if (!sample.sensor_level) begin
               if (on_ext > on_max_ff) on_max_in = on_ext;
               if (on_ext < on_min_ff) on_min_in = on_ext;
               off_count_in = '0;
               mode_in      = cpsw_pkg::MODE_OFF;
            end
         end
         cpsw_pkg::MODE_SIM_OFF: begin
            off_count_in = off_sat;
            if (!sample.belt_running) begin
               mode_in = cpsw_pkg::MODE_BELT_OFF;
            end else if (!sample.sensor_level) begin
               off_count_in = '0;
               mode_in      = cpsw_pkg::MODE_OFF;
            end else if (off_ext > off_lim_ext) begin
               on_count_in = '0;
               det         = 1'b1;
               mode_in     = cpsw_pkg::MODE_ON;
            end
         end
         default: begin
            on_count_in  = '0;
            off_count_in = '0;
            off_min_in   = STAT_MIN0;
            off_max_in   = '0;
            on_min_in    = STAT_MIN0;
            on_max_in    = '0;
            mode_in      = cpsw_pkg::MODE_BELT_OFF;
         end
      endcase
   end

   always_comb begin
      result.pulse_detected = det;
      result.alarm_off_long = aoff;
      result.alarm_on_long  = aon;
      result.off_time_min   = off_min_in[cpsw_pkg::STAT_OUT_WIDTH-1:0];
      result.off_time_max   = off_max_in[cpsw_pkg::STAT_OUT_WIDTH-1:0];
      result.on_time_min    = on_min_in[cpsw_pkg::STAT_OUT_WIDTH-1:0];
      result.on_time_max    = on_max_in[cpsw_pkg::STAT_OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cpsw_pkg::MODE_INIT;
         on_count_ff  <= '0;
         off_count_ff <= '0;
         off_min_ff   <= STAT_MIN0;
         off_max_ff   <= '0;
         on_min_ff    <= STAT_MIN0;
         on_max_ff    <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         on_count_ff  <= on_count_in;
         off_count_ff <= off_count_in;
         off_min_ff   <= off_min_in;
         off_max_ff   <= off_max_in;
         on_min_ff    <= on_min_in;
         on_max_ff    <= on_max_in;
      end
   end

   check_alarm_excl: assert property (@(posedge clock) disable iff (reset)
      advance |-> !(aoff && aon))
      else $error("both alarms raised on one sample");

   check_alarm_det: assert property (@(posedge clock) disable iff (reset)
      (advance && aoff) |-> det)
      else $error("off alarm without fake pulse");

   check_belt_stop: assert property (@(posedge clock) disable iff (reset)
      (advance && !sample.belt_running && mode_ff != cpsw_pkg::MODE_INIT &&
       mode_ff != cpsw_pkg::MODE_BELT_OFF && mode_ff <= cpsw_pkg::MODE_SIM_OFF)
      |=> mode_ff == cpsw_pkg::MODE_BELT_OFF)
      else $error("belt stop did not return to belt off");

endmodule

[src/conveyor_pulse_sensor_watchdog.sv]
// ----------------------------------------------------------------------------
// conveyor_pulse_sensor_watchdog
// Missing-pulse detector for a conveyor flight sensor with duration stats.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while req_stall is low; the
// mode/counter update is a single registered step, and a two-deep output
// buffer keeps req_stall registered. Results enter its first free slot.
// Reset: synchronous; mode goes to init, counts and maximums clear, minimums
// load STAT_RESET_MIN, registers take their defaults, both output slots empty.
module conveyor_pulse_sensor_watchdog #(
   parameter int unsigned TICK_STEP   = 10,
   parameter int unsigned COUNT_WIDTH = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cpsw_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cpsw_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [cpsw_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [cpsw_pkg::CFG_WIDTH-1:0]        csr_wdata
);

   cpsw_pkg::cfg_type cfg_ff;
   cpsw_pkg::rsp_type result;
   cpsw_pkg::rsp_type rsp_data_ff, rsp_data_in;
   cpsw_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              accept, rsp_take, out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || rsp_take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_filter_time <= cpsw_pkg::ON_FILTER_TIME_RESET;
         cfg_ff.off_time_limit <= cpsw_pkg::OFF_TIME_LIMIT_RESET;
         cfg_ff.on_time_limit  <= cpsw_pkg::ON_TIME_LIMIT_RESET;
      end else if (csr_wr_en) begin
         priority case (csr_index)
            cpsw_pkg::CSR_ON_FILTER_TIME: cfg_ff.on_filter_time <= csr_wdata;
            cpsw_pkg::CSR_OFF_TIME_LIMIT: cfg_ff.off_time_limit <= csr_wdata;
            cpsw_pkg::CSR_ON_TIME_LIMIT:  cfg_ff.on_time_limit  <= csr_wdata;
            default: ;
         endcase
      end
   end

   cpsw_core #(
      .TICK_STEP   (TICK_STEP),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg_ff),
      .sample  (req_data),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         rsp_valid_in  = skid_valid_ff || accept;
         rsp_data_in   = skid_valid_ff ? skid_data_ff : result;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   check_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot holds a transaction ahead of the output slot");

   check_result_lands: assert property (@(posedge clock) disable iff (reset)
      (accept && out_free) |=> rsp_valid_ff && rsp_data_ff == $past(result))
      else $error("accepted transaction did not reach the output");

   check_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_take) |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid slot did not drain into the output");

endmodule
